// ===== rtl/core/btip_pkg.sv =====
`timescale 1ns / 1ps

package btip_pkg;

    localparam int MAX_X_POINTS = 8;
    localparam int MAX_Y_POINTS = 8;
    localparam int VALUE_WIDTH  = 32;

    localparam int IDX_W   = $clog2(MAX_X_POINTS);
    localparam int TADDR_W = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
    localparam int CNT_W   = 4;
    localparam int DIST_W  = VALUE_WIDTH + 1;      // signed point difference
    localparam int MAG_W   = VALUE_WIDTH;          // magnitude of a difference
    localparam int LIM_EXP = 60;                   // intermediate clamp 2^60
    localparam int MID_W   = LIM_EXP + 2;          // signed row value
    localparam int PROD_W  = MID_W + MAG_W;        // magnitude product
    localparam int STEP_W  = $clog2(PROD_W);

    localparam logic [1:0] MODE_LOAD_X = 2'd0;
    localparam logic [1:0] MODE_LOAD_Y = 2'd1;
    localparam logic [1:0] MODE_LOAD_T = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_SAT    = 2'd1;
    localparam logic [1:0] STAT_ZERO_W = 2'd2;

    localparam logic REG_X_USED = 1'b0;
    localparam logic REG_Y_USED = 1'b1;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_T = 2'd2;

    typedef struct packed {
        logic done;
        logic sat;
    } lerp_stat_t;

    // last breakpoint index in use, count clamped to 2..MAX
    function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] cnt,
                                                    input int unsigned max_pts);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (n < CNT_W'(2)) begin
            n = CNT_W'(2);
        end else if (n > CNT_W'(max_pts)) begin
            n = CNT_W'(max_pts);
        end
        return IDX_W'(n - CNT_W'(1));
    endfunction

endpackage

// ===== rtl/core/btip_store.sv =====
`timescale 1ns / 1ps

module btip_store import btip_pkg::*; (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [1:0]              wr_mode,
    input  logic [IDX_W-1:0]        wr_row,
    input  logic [IDX_W-1:0]        wr_col,
    input  logic [VALUE_WIDTH-1:0]  wr_data,
    input  logic [1:0]              rd_sel,
    input  logic [TADDR_W-1:0]      rd_addr,
    output logic [VALUE_WIDTH-1:0]  rd_data
);

    logic [VALUE_WIDTH-1:0] x_mem [MAX_X_POINTS];
    logic [VALUE_WIDTH-1:0] y_mem [MAX_Y_POINTS];
    logic [VALUE_WIDTH-1:0] t_mem [MAX_X_POINTS * MAX_Y_POINTS];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            unique case (wr_mode)
                MODE_LOAD_X: x_mem[wr_row] <= wr_data;
                MODE_LOAD_Y: y_mem[wr_col] <= wr_data;
                MODE_LOAD_T: t_mem[{wr_row, wr_col}] <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (rd_sel)
            SEL_X:   rd_data_reg <= x_mem[rd_addr[IDX_W-1:0]];
            SEL_Y:   rd_data_reg <= y_mem[rd_addr[IDX_W-1:0]];
            default: rd_data_reg <= t_mem[rd_addr];
        endcase
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/btip_lerp.sv =====
`timescale 1ns / 1ps

// a + round((b - a) * d / w): bit-serial multiply then restoring divide
module btip_lerp import btip_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [MID_W-1:0]  a,
    input  logic signed [MID_W-1:0]  b,
    input  logic signed [DIST_W-1:0] d,
    input  logic signed [DIST_W-1:0] w,
    output lerp_stat_t               stat,
    output logic signed [MID_W-1:0]  result
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_MAG  = 3'd1;
    localparam logic [2:0] L_MUL  = 3'd2;
    localparam logic [2:0] L_DIV  = 3'd3;
    localparam logic [2:0] L_RND  = 3'd4;
    localparam logic [2:0] L_ADD  = 3'd5;
    localparam logic [2:0] L_DONE = 3'd6;

    localparam logic [PROD_W-1:0]   LIM_Q  = PROD_W'(1) << LIM_EXP;
    localparam logic [LIM_EXP:0]    LIM_M  = (LIM_EXP+1)'(1) << LIM_EXP;
    localparam logic signed [MID_W:0] LIM_S = (MID_W+1)'(1) << LIM_EXP;

    logic [2:0]               st_reg, st_next;
    logic signed [MID_W-1:0]  a_reg, a_next;
    logic signed [MID_W:0]    diff_reg, diff_next;
    logic signed [DIST_W-1:0] d_reg, d_next, w_reg, w_next;
    logic                     neg_reg, neg_next;
    logic [MAG_W-1:0]         md_reg, md_next, mw_reg, mw_next;
    logic [MID_W-1:0]         mdiff_reg, mdiff_next;
    logic [PROD_W-1:0]        acc_reg, acc_next;
    logic [MAG_W-1:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic [LIM_EXP:0]         mag_reg, mag_next;
    logic                     sat_reg, sat_next;
    logic signed [MID_W-1:0]  res_reg, res_next;

    logic [MAG_W:0]           rem_sh;
    logic                     ge;
    logic                     rnd;
    logic [LIM_EXP:0]         mag_sum;
    logic signed [MID_W:0]    sum;

    always_comb begin
        st_next    = st_reg;
        a_next     = a_reg;
        diff_next  = diff_reg;
        d_next     = d_reg;
        w_next     = w_reg;
        neg_next   = neg_reg;
        md_next    = md_reg;
        mw_next    = mw_reg;
        mdiff_next = mdiff_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        sat_next   = sat_reg;
        res_next   = res_reg;
        rem_sh     = {rem_reg, acc_reg[PROD_W-1]};
        ge         = rem_sh >= {1'b0, mw_reg};
        rnd        = rem_reg >= (mw_reg - rem_reg);
        mag_sum    = acc_reg[LIM_EXP:0] + (LIM_EXP+1)'(rnd);
        sum        = neg_reg ? ({a_reg[MID_W-1], a_reg} - $signed({2'b00, mag_reg}))
                             : ({a_reg[MID_W-1], a_reg} + $signed({2'b00, mag_reg}));
        unique case (st_reg)
            L_IDLE: begin
                if (start) begin
                    a_next    = a;
                    diff_next = {b[MID_W-1], b} - {a[MID_W-1], a};
                    d_next    = d;
                    w_next    = w;
                    sat_next  = 1'b0;
                    st_next   = L_MAG;
                end
            end
            L_MAG: begin
                neg_next   = diff_reg[MID_W] ^ d_reg[DIST_W-1] ^ w_reg[DIST_W-1];
                mdiff_next = diff_reg[MID_W] ? MID_W'(-diff_reg) : MID_W'(diff_reg);
                md_next    = d_reg[DIST_W-1] ? MAG_W'(-d_reg) : MAG_W'(d_reg);
                mw_next    = w_reg[DIST_W-1] ? MAG_W'(-w_reg) : MAG_W'(w_reg);
                acc_next   = '0;
                rem_next   = '0;
                cnt_next   = '0;
                st_next    = L_MUL;
            end
            L_MUL: begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (md_reg[MAG_W-1] ? PROD_W'(mdiff_reg) : PROD_W'(0));
                md_next  = {md_reg[MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(MAG_W - 1)) begin
                    cnt_next = '0;
                    st_next  = L_DIV;
                end
            end
            L_DIV: begin
                rem_next = ge ? MAG_W'(rem_sh - {1'b0, mw_reg}) : rem_sh[MAG_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], ge};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(PROD_W - 1)) begin
                    st_next = L_RND;
                end
            end
            L_RND: begin
                if (acc_reg > LIM_Q) begin
                    sat_next = 1'b1;
                    mag_next = LIM_M;
                end else if (mag_sum > LIM_M) begin
                    sat_next = 1'b1;
                    mag_next = LIM_M;
                end else begin
                    mag_next = mag_sum;
                end
                st_next = L_ADD;
            end
            L_ADD: begin
                if (sum > LIM_S) begin
                    sat_next = 1'b1;
                    res_next = MID_W'(LIM_S);
                end else if (sum < -LIM_S) begin
                    sat_next = 1'b1;
                    res_next = MID_W'(-LIM_S);
                end else begin
                    res_next = MID_W'(sum);
                end
                st_next = L_DONE;
            end
            L_DONE: st_next = L_IDLE;
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= L_IDLE;
        end else begin
            st_reg <= st_next;
        end
        a_reg     <= a_next;
        diff_reg  <= diff_next;
        d_reg     <= d_next;
        w_reg     <= w_next;
        neg_reg   <= neg_next;
        md_reg    <= md_next;
        mw_reg    <= mw_next;
        mdiff_reg <= mdiff_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        mag_reg   <= mag_next;
        sat_reg   <= sat_next;
        res_reg   <= res_next;
    end

    assign stat.done = (st_reg == L_DONE);
    assign stat.sat  = sat_reg;
    assign result    = res_reg;

endmodule

// ===== rtl/core/bilinear_table_interpolator_core.sv =====
`timescale 1ns / 1ps

// Two-axis Q16.16 lookup table with bilinear interpolation. A load beat
// (x point, y point or table value) is written in the cycle it is taken and
// gives no result. A query beat gives one result beat; it runs a breakpoint
// search on each axis, an operand fetch, difference setup and, unless a
// segment has zero width, three passes through the shared interpolation
// unit (32-step bit-serial multiply plus 94-step restoring divide), then a
// final clamp and output. s_tready is low while a query is being worked.
// Store entries read by a query must have been written first.
module bilinear_table_interpolator_core import btip_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], row_index[4:2], col_index[7:5], load_data[39:8],
    // query_x[71:40], query_y[103:72]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // interp_value[31:0], status[33:32], zero fill
    output logic [39:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [3:0]   cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SXRD  = 4'd1;
    localparam logic [3:0] S_SXCMP = 4'd2;
    localparam logic [3:0] S_SYRD  = 4'd3;
    localparam logic [3:0] S_SYCMP = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_CALCX = 4'd6;
    localparam logic [3:0] S_CALCY = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_LGO   = 4'd9;
    localparam logic [3:0] S_LWAIT = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam int FETCH_N = 8;
    localparam logic signed [MID_W-1:0] VMAX = MID_W'(2**(VALUE_WIDTH-1) - 1);
    localparam logic signed [MID_W-1:0] VMIN = MID_W'(-(2**(VALUE_WIDTH-1)));

    logic [1:0]               in_mode;
    logic [IDX_W-1:0]         in_row, in_col;
    logic [VALUE_WIDTH-1:0]   in_load;
    logic                     s_acc;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         xu_reg, xu_next, yu_reg, yu_next;
    logic signed [VALUE_WIDTH-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic signed [VALUE_WIDTH-1:0] prev_reg, prev_next;
    logic                     found_reg, found_next, lt0_reg, lt0_next;
    logic [IDX_W-1:0]         fseg_reg, fseg_next, sx_reg, sx_next, sy_reg, sy_next;
    logic [CNT_W-1:0]         fk_reg, fk_next;
    logic [VALUE_WIDTH-1:0]   fv_reg [FETCH_N];
    logic [VALUE_WIDTH-1:0]   fv_next [FETCH_N];
    logic signed [DIST_W-1:0] dx_reg, dx_next, wx_reg, wx_next;
    logic signed [DIST_W-1:0] dy_reg, dy_next, wy_reg, wy_next;
    logic [1:0]               lsel_reg, lsel_next;
    logic signed [MID_W-1:0]  r0_reg, r0_next, r1_reg, r1_next;
    logic                     sat_reg, sat_next;
    logic [VALUE_WIDTH-1:0]   val_reg, val_next;
    logic [1:0]               stat_reg, stat_next;
    logic                     mv_reg, mv_next;
    logic [VALUE_WIDTH+1:0]   md_reg, md_next;

    logic [1:0]               rd_sel;
    logic [TADDR_W-1:0]       rd_addr;
    logic [VALUE_WIDTH-1:0]   rd_data;
    logic signed [VALUE_WIDTH-1:0] p_val, v_val;
    logic [IDX_W-1:0]         last_idx;
    logic                     found_c, lt0_c;
    logic [IDX_W-1:0]         fseg_c, seg_c;
    logic [IDX_W-1:0]         sx1, sy1;
    logic                     lerp_start;
    logic signed [MID_W-1:0]  la, lb, lres;
    logic signed [DIST_W-1:0] ld, lw;
    lerp_stat_t               lstat;

    assign in_mode = s_tdata[1:0];
    assign in_row  = s_tdata[4:2];
    assign in_col  = s_tdata[7:5];
    assign in_load = s_tdata[39:8];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign sx1 = sx_reg + IDX_W'(1);
    assign sy1 = sy_reg + IDX_W'(1);

    btip_store u_store (
        .aclk    (aclk),
        .wr_en   (s_acc && (in_mode != MODE_QUERY)),
        .wr_mode (in_mode),
        .wr_row  (in_row),
        .wr_col  (in_col),
        .wr_data (in_load),
        .rd_sel  (rd_sel),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        la = MID_W'($signed(fv_reg[4]));
        lb = MID_W'($signed(fv_reg[5]));
        ld = dx_reg;
        lw = wx_reg;
        unique case (lsel_reg)
            2'd0: ;
            2'd1: begin
                la = MID_W'($signed(fv_reg[6]));
                lb = MID_W'($signed(fv_reg[7]));
            end
            default: begin
                la = r0_reg;
                lb = r1_reg;
                ld = dy_reg;
                lw = wy_reg;
            end
        endcase
    end

    btip_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start),
        .a       (la),
        .b       (lb),
        .d       (ld),
        .w       (lw),
        .stat    (lstat),
        .result  (lres)
    );

    // read address for the scan and the operand fetch
    always_comb begin
        rd_sel  = SEL_X;
        rd_addr = TADDR_W'(i_reg);
        unique case (state_reg)
            S_SYRD: rd_sel = SEL_Y;
            S_FETCH: begin
                unique case (fk_reg[2:0])
                    3'd0: rd_addr = TADDR_W'(sx_reg);
                    3'd1: rd_addr = TADDR_W'(sx1);
                    3'd2: begin
                        rd_sel  = SEL_Y;
                        rd_addr = TADDR_W'(sy_reg);
                    end
                    3'd3: begin
                        rd_sel  = SEL_Y;
                        rd_addr = TADDR_W'(sy1);
                    end
                    3'd4: begin
                        rd_sel  = SEL_T;
                        rd_addr = {sx_reg, sy_reg};
                    end
                    3'd5: begin
                        rd_sel  = SEL_T;
                        rd_addr = {sx1, sy_reg};
                    end
                    3'd6: begin
                        rd_sel  = SEL_T;
                        rd_addr = {sx_reg, sy1};
                    end
                    default: begin
                        rd_sel  = SEL_T;
                        rd_addr = {sx1, sy1};
                    end
                endcase
            end
            default: ;
        endcase
    end

    // segment search step: one breakpoint per compare cycle
    always_comb begin
        p_val    = $signed(rd_data);
        v_val    = (state_reg == S_SYCMP) ? qy_reg : qx_reg;
        last_idx = (state_reg == S_SYCMP) ? last_index(yu_reg, MAX_Y_POINTS)
                                          : last_index(xu_reg, MAX_X_POINTS);
        found_c  = found_reg;
        fseg_c   = fseg_reg;
        lt0_c    = lt0_reg;
        if (i_reg == '0) begin
            lt0_c   = v_val < p_val;
            found_c = 1'b0;
        end else if (!found_reg && (prev_reg <= v_val) && (v_val < p_val)) begin
            found_c = 1'b1;
            fseg_c  = i_reg - IDX_W'(1);
        end
        // above the last point wins, then a bracketing segment, then below the first
        priority if (v_val >= p_val) begin
            seg_c = last_idx - IDX_W'(1);
        end else if (found_c) begin
            seg_c = fseg_c;
        end else if (lt0_c) begin
            seg_c = '0;
        end else begin
            seg_c = last_idx - IDX_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        xu_next    = xu_reg;
        yu_next    = yu_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        i_next     = i_reg;
        prev_next  = prev_reg;
        found_next = found_reg;
        lt0_next   = lt0_reg;
        fseg_next  = fseg_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        fk_next    = fk_reg;
        fv_next    = fv_reg;
        dx_next    = dx_reg;
        wx_next    = wx_reg;
        dy_next    = dy_reg;
        wy_next    = wy_reg;
        lsel_next  = lsel_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        sat_next   = sat_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        lerp_start = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_X_USED: xu_next = cfg_data;
                REG_Y_USED: yu_next = cfg_data;
            endcase
        end

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && (in_mode == MODE_QUERY)) begin
                    qx_next    = $signed(s_tdata[71:40]);
                    qy_next    = $signed(s_tdata[103:72]);
                    i_next     = '0;
                    state_next = S_SXRD;
                end
            end
            S_SXRD, S_SYRD: begin
                state_next = (state_reg == S_SXRD) ? S_SXCMP : S_SYCMP;
            end
            S_SXCMP, S_SYCMP: begin
                found_next = found_c;
                fseg_next  = fseg_c;
                lt0_next   = lt0_c;
                prev_next  = p_val;
                if (i_reg == last_idx) begin
                    i_next = '0;
                    if (state_reg == S_SXCMP) begin
                        sx_next    = seg_c;
                        state_next = S_SYRD;
                    end else begin
                        sy_next    = seg_c;
                        fk_next    = '0;
                        state_next = S_FETCH;
                    end
                end else begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = (state_reg == S_SXCMP) ? S_SXRD : S_SYRD;
                end
            end
            S_FETCH: begin
                if (fk_reg != '0) begin
                    fv_next[fk_reg[2:0] - 3'd1] = rd_data;
                end
                fk_next = fk_reg + CNT_W'(1);
                if (fk_reg == CNT_W'(FETCH_N)) begin
                    state_next = S_CALCX;
                end
            end
            S_CALCX: begin
                dx_next    = {qx_reg[VALUE_WIDTH-1], qx_reg}
                           - $signed({fv_reg[0][VALUE_WIDTH-1], fv_reg[0]});
                wx_next    = $signed({fv_reg[1][VALUE_WIDTH-1], fv_reg[1]})
                           - $signed({fv_reg[0][VALUE_WIDTH-1], fv_reg[0]});
                state_next = S_CALCY;
            end
            S_CALCY: begin
                dy_next    = {qy_reg[VALUE_WIDTH-1], qy_reg}
                           - $signed({fv_reg[2][VALUE_WIDTH-1], fv_reg[2]});
                wy_next    = $signed({fv_reg[3][VALUE_WIDTH-1], fv_reg[3]})
                           - $signed({fv_reg[2][VALUE_WIDTH-1], fv_reg[2]});
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if ((wx_reg == '0) || (wy_reg == '0)) begin
                    val_next   = '0;
                    stat_next  = STAT_ZERO_W;
                    state_next = S_OUT;
                end else begin
                    lsel_next  = 2'd0;
                    sat_next   = 1'b0;
                    state_next = S_LGO;
                end
            end
            S_LGO: begin
                lerp_start = 1'b1;
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                if (lstat.done) begin
                    sat_next = sat_reg | lstat.sat;
                    unique case (lsel_reg)
                        2'd0: begin
                            r0_next    = lres;
                            lsel_next  = 2'd1;
                            state_next = S_LGO;
                        end
                        2'd1: begin
                            r1_next    = lres;
                            lsel_next  = 2'd2;
                            state_next = S_LGO;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_FIN: begin
                if (lres > VMAX) begin
                    val_next  = VALUE_WIDTH'(VMAX);
                    stat_next = STAT_SAT;
                end else if (lres < VMIN) begin
                    val_next  = VALUE_WIDTH'(VMIN);
                    stat_next = STAT_SAT;
                end else begin
                    val_next  = VALUE_WIDTH'(lres);
                    stat_next = sat_reg ? STAT_SAT : STAT_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    md_next    = {stat_reg, val_reg};
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            xu_reg    <= CNT_W'(MAX_X_POINTS);
            yu_reg    <= CNT_W'(MAX_Y_POINTS);
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            xu_reg    <= xu_next;
            yu_reg    <= yu_next;
            mv_reg    <= mv_next;
        end
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        i_reg     <= i_next;
        prev_reg  <= prev_next;
        found_reg <= found_next;
        lt0_reg   <= lt0_next;
        fseg_reg  <= fseg_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        fk_reg    <= fk_next;
        fv_reg    <= fv_next;
        dx_reg    <= dx_next;
        wx_reg    <= wx_next;
        dy_reg    <= dy_next;
        wy_reg    <= wy_next;
        lsel_reg  <= lsel_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        sat_reg   <= sat_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        md_reg    <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'b000000, md_reg};

endmodule

// ===== rtl/core/btip_checker.sv =====
`timescale 1ns / 1ps

module btip_checker import btip_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [103:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    // a query beat blocks the input side on the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == MODE_QUERY) |=> !s_tready)
        else $error("input ready right after a query beat");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] == STAT_OK) || (m_tdata[33:32] == STAT_SAT)
                     || (m_tdata[33:32] == STAT_ZERO_W))
        else $error("bad status code");

    a_zero_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == STAT_ZERO_W) |-> (m_tdata[31:0] == '0))
        else $error("zero-width segment with nonzero value");

    // a result never appears in the cycle after a query beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == MODE_QUERY) && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind bilinear_table_interpolator_core btip_checker u_btip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/bilinear_table_interpolator_core_tb.sv =====
`timescale 1ns / 1ps

module bilinear_table_interpolator_core_tb;
    import btip_pkg::*;

    localparam longint MID_LIM = 64'sd1 << LIM_EXP;

    typedef struct {
        logic [1:0]  mode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] load_data;
        logic [31:0] query_x;
        logic [31:0] query_y;
    } beat_t;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_addr = REG_X_USED;
    logic [3:0]   cfg_data = '0;

    bilinear_table_interpolator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    beat_t   pending_beats[$];
    result_t expected_results[$];

    // mirror of the block's state
    longint   mdl_x[MAX_X_POINTS];
    longint   mdl_y[MAX_Y_POINTS];
    longint   mdl_tab[MAX_X_POINTS * MAX_Y_POINTS];
    logic [3:0] mdl_nx = 4'd8;
    logic [3:0] mdl_ny = 4'd8;

    // generator-side copy of the axes, used to aim queries
    int gen_x[8];
    int gen_y[8];
    int gen_nx = 8;
    int gen_ny = 8;

    int err_count = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_sat = 0;
    int n_zero_w = 0;
    int n_items = 0;
    int rx_long_hold = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit in_took = 1'b0;
    bit out_took = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;

    function automatic int clamp_count(logic [3:0] c);
        if (c < 2) return 2;
        if (c > 8) return 8;
        return int'(c);
    endfunction

    function automatic int find_segment(longint p[8], int n, longint v);
        int s;
        s = n - 2;
        if (v < p[0]) s = 0;
        for (int i = 1; i < n; i++) begin
            if (p[i-1] <= v && v < p[i]) begin
                s = i - 1;
                break;
            end
        end
        if (v >= p[n-1]) s = n - 2;
        return s;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // a + round((b - a) * d / w), halves away from zero, clamped to +-2^60
    function automatic longint blend(longint a, longint b, longint d, longint w,
                                     inout bit sat);
        longint diff;
        bit neg;
        logic [127:0] num, quo, rem, wm;
        longint unsigned mag;
        longint r;
        diff = b - a;
        neg = (diff < 0) ^ (d < 0) ^ (w < 0);
        num = 128'(magnitude(diff)) * 128'(magnitude(d));
        wm = 128'(magnitude(w));
        quo = num / wm;
        rem = num % wm;
        if (quo > 128'(MID_LIM)) begin
            sat = 1'b1;
            mag = MID_LIM;
        end else begin
            mag = quo[63:0];
            if (rem >= wm - rem) mag++;
            if (mag > MID_LIM) begin
                sat = 1'b1;
                mag = MID_LIM;
            end
        end
        r = neg ? a - longint'(mag) : a + longint'(mag);
        if (r > MID_LIM) begin
            sat = 1'b1;
            r = MID_LIM;
        end else if (r < -MID_LIM) begin
            sat = 1'b1;
            r = -MID_LIM;
        end
        return r;
    endfunction

    function automatic longint tab_at(int xi, int yi);
        return mdl_tab[xi * MAX_Y_POINTS + yi];
    endfunction

    // apply one accepted beat to the mirror; queries queue their result
    task automatic interp_predict(beat_t b);
        int nx, ny, sx, sy;
        longint qx, qy, dx, wx, dy, wy, r0, r1, r;
        bit sat;
        result_t res;
        sat = 1'b0;
        case (b.mode)
            MODE_LOAD_X: mdl_x[b.row] = longint'(signed'(b.load_data));
            MODE_LOAD_Y: mdl_y[b.col] = longint'(signed'(b.load_data));
            MODE_LOAD_T: mdl_tab[b.row * MAX_Y_POINTS + b.col] =
                             longint'(signed'(b.load_data));
            default: begin
                nx = clamp_count(mdl_nx);
                ny = clamp_count(mdl_ny);
                qx = longint'(signed'(b.query_x));
                qy = longint'(signed'(b.query_y));
                sx = find_segment(mdl_x, nx, qx);
                sy = find_segment(mdl_y, ny, qy);
                dx = qx - mdl_x[sx];
                wx = mdl_x[sx+1] - mdl_x[sx];
                dy = qy - mdl_y[sy];
                wy = mdl_y[sy+1] - mdl_y[sy];
                if (wx == 0 || wy == 0) begin
                    res.value = '0;
                    res.status = STAT_ZERO_W;
                    n_zero_w++;
                end else begin
                    r0 = blend(tab_at(sx, sy), tab_at(sx+1, sy), dx, wx, sat);
                    r1 = blend(tab_at(sx, sy+1), tab_at(sx+1, sy+1), dx, wx, sat);
                    r = blend(r0, r1, dy, wy, sat);
                    if (r > 64'sd2147483647) begin
                        r = 64'sd2147483647;
                        sat = 1'b1;
                    end else if (r < -64'sd2147483648) begin
                        r = -64'sd2147483648;
                        sat = 1'b1;
                    end
                    res.value = r[31:0];
                    res.status = sat ? STAT_SAT : STAT_OK;
                    if (sat) n_sat++;
                end
                expected_results.push_back(res);
                n_queries++;
            end
        endcase
        if (b.mode != MODE_QUERY) n_loads++;
    endtask

    function automatic int idle_draw(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // sample handshakes at the rising edge
    always @(posedge aclk) begin
        in_took = aresetn && s_tvalid && s_tready;
        out_took = aresetn && m_tvalid && m_tready;
        if (in_took) interp_predict(pending_beats.pop_front());
        if (out_took) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: interp_value %0d status %0d",
                       $signed(m_tdata[31:0]), m_tdata[33:32]);
                err_count++;
            end else begin
                result_t e;
                e = expected_results.pop_front();
                if (m_tdata[31:0] !== e.value) begin
                    $error("interp_value expected %0d got %0d",
                           $signed(e.value), $signed(m_tdata[31:0]));
                    err_count++;
                end
                if (m_tdata[33:32] !== e.status) begin
                    $error("status expected %0d got %0d", e.status, m_tdata[33:32]);
                    err_count++;
                end
            end
        end
    end

    // sender: the offered beat stays at the head of pending_beats until taken
    bit offering = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (offering && !in_took) begin
            // hold the beat
        end else if (tx_gap > 0) begin
            offering = 1'b0;
            s_tvalid <= 1'b0;
            tx_gap--;
        end else if (pending_beats.size() > 0 && !(offering && in_took &&
                     pending_beats.size() == 0)) begin
            beat_t b;
            b = pending_beats[0];
            s_tdata <= {b.query_y, b.query_x, b.load_data, b.col, b.row, b.mode};
            s_tvalid <= 1'b1;
            offering = 1'b1;
            tx_gap = idle_draw(tx_burst);
        end else begin
            offering = 1'b0;
            s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_long_hold > 0) begin
            m_tready <= 1'b0;
            rx_long_hold--;
        end else begin
            if (out_took) rx_gap = idle_draw(rx_burst);
            if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_load(logic [1:0] mode, int idx, int other, int val);
        beat_t b;
        b.mode = mode;
        b.row = (mode == MODE_LOAD_Y) ? 3'($urandom) : 3'(idx);
        b.col = (mode == MODE_LOAD_X) ? 3'($urandom) :
                (mode == MODE_LOAD_Y) ? 3'(idx) : 3'(other);
        b.load_data = val;
        b.query_x = $urandom;
        b.query_y = $urandom;
        pending_beats.push_back(b);
        n_items++;
    endtask

    task automatic push_query(int qx, int qy);
        beat_t b;
        b.mode = MODE_QUERY;
        b.row = $urandom;
        b.col = $urandom;
        b.load_data = $urandom;
        b.query_x = qx;
        b.query_y = qy;
        pending_beats.push_back(b);
        n_items++;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || offering || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_counts(logic [3:0] nx, logic [3:0] ny);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_X_USED;
        cfg_data <= nx;
        @(negedge aclk);
        cfg_addr <= REG_Y_USED;
        cfg_data <= ny;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_data <= $urandom;
        mdl_nx = nx;
        mdl_ny = ny;
        gen_nx = clamp_count(nx);
        gen_ny = clamp_count(ny);
    endtask

    // axis shapes: sorted, sorted with a repeated point, unsorted, full-range
    task automatic make_axis(int shape, output int a[8]);
        longint v;
        v = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        for (int i = 0; i < 8; i++) begin
            case (shape)
                0, 1: begin
                    a[i] = int'(v);
                    v += $urandom_range(1, ($urandom_range(0, 1) != 0) ? 16 : (1 << 21));
                end
                2: a[i] = $urandom;
                default: a[i] = int'(-64'sd2147483648 + i * 64'sd613566756);
            endcase
        end
        if (shape == 1) begin
            int k;
            k = $urandom_range(1, 7);
            a[k] = a[k-1];
        end
    endtask

    function automatic int aim(int a[8], int n);
        longint lo, hi;
        int i;
        i = $urandom_range(0, n - 2);
        lo = a[i] < a[i+1] ? a[i] : a[i+1];
        hi = a[i] < a[i+1] ? a[i+1] : a[i];
        case ($urandom_range(0, 7))
            0: return a[$urandom_range(0, n - 1)];
            1: return $urandom;
            2: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return int'(longint'(a[0]) - $urandom_range(1, 1 << 22));
            4: return int'(longint'(a[n-1]) + $urandom_range(0, 1 << 22));
            default: return int'(lo + longint'($urandom) % (hi - lo + 1));
        endcase
    endfunction

    function automatic int table_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 1 << 25) - (1 << 24);
    endfunction

    task automatic load_axes(int shape_x, int shape_y);
        make_axis(shape_x, gen_x);
        make_axis(shape_y, gen_y);
        for (int i = 0; i < 8; i++) push_load(MODE_LOAD_X, i, 0, gen_x[i]);
        for (int i = 0; i < 8; i++) push_load(MODE_LOAD_Y, i, 0, gen_y[i]);
    endtask

    task automatic random_phase(int n_tab, int n_q);
        int sh;
        sh = $urandom_range(0, 9);
        load_axes(sh < 6 ? 0 : sh < 8 ? 1 : sh == 8 ? 2 : 3,
                  $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
        for (int i = 0; i < n_tab; i++)
            push_load(MODE_LOAD_T, $urandom_range(0, 7), $urandom_range(0, 7),
                      table_value());
        for (int i = 0; i < n_q; i++) begin
            // a few loads mixed in between queries
            if ($urandom_range(0, 9) == 0)
                push_load(MODE_LOAD_T, $urandom_range(0, 7), $urandom_range(0, 7),
                          table_value());
            push_query(aim(gen_x, gen_nx), aim(gen_y, gen_ny));
        end
    endtask

    logic [3:0] cfg_plan[7][2] = '{'{8, 8}, '{2, 2}, '{2, 8}, '{8, 2},
                                  '{0, 15}, '{1, 9}, '{5, 3}};

    initial begin
        int ph;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // fill every store entry before any query
        write_counts(4'd8, 4'd8);
        load_axes(0, 0);
        for (int i = 0; i < 64; i++) push_load(MODE_LOAD_T, i / 8, i % 8, table_value());
        // directed: breakpoints, ends, extremes
        push_query(gen_x[0], gen_y[0]);
        push_query(gen_x[7], gen_y[7]);
        push_query(gen_x[3], gen_y[5]);
        push_query(32'h7fff_ffff, 32'h7fff_ffff);
        push_query(32'h8000_0000, 32'h8000_0000);
        push_query(32'h8000_0000, 32'h7fff_ffff);
        push_query(gen_x[0] - 1, gen_y[7] + 1);
        push_query(int'((longint'(gen_x[2]) + gen_x[3]) / 2), gen_y[1] + 1);
        // saturation: extreme corners and far extrapolation
        push_load(MODE_LOAD_T, 0, 0, 32'h7fff_ffff);
        push_load(MODE_LOAD_T, 1, 0, 32'h8000_0000);
        push_load(MODE_LOAD_T, 0, 1, 32'h8000_0000);
        push_load(MODE_LOAD_T, 1, 1, 32'h7fff_ffff);
        push_query(32'h8000_0000, gen_y[0]);
        push_query(32'h8000_0000, 32'h8000_0000);
        push_query(gen_x[0], 32'h8000_0000);
        push_query(int'((longint'(gen_x[0]) + gen_x[1]) / 2), gen_y[0]);
        // repeated breakpoint: zero-width segment
        push_load(MODE_LOAD_X, 1, 0, gen_x[0]);
        push_query(gen_x[0], gen_y[0]);
        push_query(32'h8000_0000, gen_y[2]);
        push_load(MODE_LOAD_X, 1, 0, gen_x[1]);

        ph = 0;
        while (n_items < 1150) begin
            if (ph < 7) write_counts(cfg_plan[ph][0], cfg_plan[ph][1]);
            else if (ph % 3 == 0)
                write_counts(4'($urandom_range(0, 15)), 4'($urandom_range(2, 8)));
            if (ph == 3) begin
                // back up the result side so the block stalls its input
                wait_idle();
                rx_long_hold = 3000;
            end
            if (ph == 5) begin
                random_phase(16, 10);
                wait_idle();
                random_phase(0, 10);
            end else begin
                random_phase(16, 28);
            end
            ph++;
        end

        wait_idle();
        repeat (600) @(posedge aclk);
        $display("covered %0d beats: %0d loads, %0d queries (%0d saturated, %0d zero-width)",
                 n_items, n_loads, n_queries, n_sat, n_zero_w);
        $display("%0d axis/count settings including clamped register values", ph + 1);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("** bilinear_table_interpolator_core: PASSED **");
        end else begin
            $display("** bilinear_table_interpolator_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout");
        $display("** bilinear_table_interpolator_core: FAILED **");
        $finish;
    end

endmodule
